// ----- hw/rtl/aligned_block_allocator_defines.svh -----
// Assertion macros used by the checker of the block allocator.
// No dependencies; include by bare file name.
`ifndef ALIGNED_BLOCK_ALLOCATOR_DEFINES_SVH
`define ALIGNED_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while reset is low
`define ABA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low
`define ABA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define ABA_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/aba_pkg.sv -----
// Shared constants, codes and types of the aligned block allocator.
// No dependencies.
package aba_pkg;

    // Region geometry
    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 16;
    localparam int MAX_RUN     = 256;

    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int OFS_W   = $clog2(BLOCK_BYTES);
    localparam int RUN_W   = $clog2(MAX_RUN);
    localparam int N_W     = RUN_W + 1;
    localparam int SLACK_W = OFS_W;

    // Field widths
    localparam int LEN_W    = 16;
    localparam int ADDR_W   = 32;
    localparam int MAXLEN_W = 13;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [ADDR_W:0]       REGION_BYTES  = (ADDR_W + 1)'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [MAXLEN_W-1:0]   MAXLEN_RESET  = MAXLEN_W'(4096);

    // Register indexes
    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_MAX_LENGTH   = 1'b1;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]   region_start;
        logic [MAXLEN_W-1:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   run_address;
    } t_rsp;

endpackage

// ----- hw/rtl/aba_engine.sv -----
// Allocation engine: block table memory, clearing sweep, first-fit scan and free.
// Depends on aba_pkg.
module aba_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aba_pkg::t_cfg i_cfg,
    input  logic          i_start,
    input  aba_pkg::t_req i_req,
    output logic          o_idle,
    output logic          o_done,
    output aba_pkg::t_rsp o_rsp,
    input  logic          i_take
);
    import aba_pkg::*;

    typedef struct packed {
        logic               used;
        logic [RUN_W-1:0]   run;
        logic [SLACK_W-1:0] slack;
    } t_entry;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_RD  = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam logic [IDX_W:0] IDX_END  = (IDX_W + 1)'(NUM_BLOCKS);
    localparam logic [IDX_W:0] IDX_LAST = (IDX_W + 1)'(NUM_BLOCKS - 1);

    // Block table, one word per block
    t_entry r_mem [NUM_BLOCKS];
    t_entry r_rd_data;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // Control and working registers
    logic [2:0]          r_state,  n_state;
    logic [IDX_W:0]      r_idx,    n_idx;
    logic                r_dv,     n_dv;
    logic [IDX_W-1:0]    r_b,      n_b;
    logic [RUN_W-1:0]    r_skip,   n_skip;
    logic [RUN_W-1:0]    r_mod,    n_mod;
    logic [N_W-1:0]      r_count,  n_count;
    logic [N_W-1:0]      r_n,      n_n;
    logic [SLACK_W-1:0]  r_slack,  n_slack;
    logic [IDX_W-1:0]    r_head,   n_head;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_alloc_ok, n_alloc_ok;

    // Request decode
    logic                  len_bad;
    logic [LEN_W-1:0]      len_m1;
    logic [LEN_W-OFS_W:0]  blocks;
    logic [ADDR_W:0]       region_end;
    logic                  addr_bad;
    logic [ADDR_W-1:0]     addr_diff;

    // Scan helpers
    logic [IDX_W+N_W-1:0] head_wide;
    logic [IDX_W-1:0]     scan_head;
    logic [ADDR_W-1:0]    head_bytes;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Length check and block count
    always_comb begin
        len_m1  = i_req.length - LEN_W'(1);
        blocks  = {1'b0, len_m1[LEN_W-1:OFS_W]} + (LEN_W - OFS_W + 1)'(1);
        len_bad = (i_req.length == '0)
               || (i_req.length > LEN_W'(i_cfg.max_length))
               || (blocks > (LEN_W - OFS_W + 1)'(MAX_RUN));
    end

    // Free address range and alignment check
    always_comb begin
        region_end = {1'b0, i_cfg.region_start} + REGION_BYTES;
        addr_bad   = (i_req.address[OFS_W-1:0] != '0)
                  || (i_req.address < i_cfg.region_start)
                  || ({1'b0, i_req.address} >= region_end);
        addr_diff  = i_req.address - i_cfg.region_start;
    end

    // Head of a run that completes at the entry under evaluation
    assign head_wide = (IDX_W + N_W)'(r_b) - (IDX_W + N_W)'(r_n) + (IDX_W + N_W)'(1);
    assign scan_head = head_wide[IDX_W-1:0];

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_dv       = r_dv;
        n_b        = r_b;
        n_skip     = r_skip;
        n_mod      = r_mod;
        n_count    = r_count;
        n_n        = r_n;
        n_slack    = r_slack;
        n_head     = r_head;
        n_status   = r_status;
        n_alloc_ok = r_alloc_ok;
        rd_en      = 1'b0;
        rd_addr    = r_idx[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx[IDX_W-1:0];
        wr_data    = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + (IDX_W + 1)'(1);
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_start) begin
                    n_alloc_ok = 1'b0;
                    if (i_req.cmd == CMD_ALLOC) begin
                        if (len_bad) begin
                            n_status = ST_BAD_LEN;
                            n_state  = S_DONE;
                        end else begin
                            n_n     = blocks[N_W-1:0];
                            n_slack = '0 - i_req.length[SLACK_W-1:0];
                            n_idx   = '0;
                            n_dv    = 1'b0;
                            n_skip  = '0;
                            n_mod   = '0;
                            n_count = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (addr_bad) begin
                            n_status = ST_BAD_ADDR;
                            n_state  = S_DONE;
                        end else begin
                            n_head  = addr_diff[IDX_W+OFS_W-1:OFS_W];
                            n_state = S_FREE_RD;
                        end
                    end
                end
            end

            S_SCAN: begin
                // stream reads, one block per cycle
                if (r_idx < IDX_END) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[IDX_W-1:0];
                    n_idx   = r_idx + (IDX_W + 1)'(1);
                    n_b     = r_idx[IDX_W-1:0];
                    n_dv    = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end

                // evaluate the block whose word just arrived
                if (r_dv) begin
                    n_mod = ({1'b0, r_mod} + N_W'(1) == r_n) ? '0 : r_mod + RUN_W'(1);
                    if (r_skip != '0) begin
                        // inside a used run
                        n_skip = r_skip - RUN_W'(1);
                    end else if (r_rd_data.used) begin
                        // used head: hop over its run, zero stands for a full run
                        n_skip  = (r_rd_data.run == '0) ? '1 : r_rd_data.run - RUN_W'(1);
                        n_count = '0;
                    end else if ((r_count == '0) && (r_mod != '0)) begin
                        // not an aligned start
                        n_count = '0;
                    end else if (r_count + N_W'(1) == r_n) begin
                        wr_en      = 1'b1;
                        wr_addr    = scan_head;
                        wr_data    = '{used: 1'b1, run: r_n[RUN_W-1:0], slack: r_slack};
                        n_head     = scan_head;
                        n_status   = ST_OK;
                        n_alloc_ok = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        n_count = r_count + N_W'(1);
                    end

                    if ((n_state == S_SCAN) && ({1'b0, r_b} == IDX_LAST)) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end
                end
            end

            S_FREE_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_FREE_CHK;
            end

            S_FREE_CHK: begin
                if (r_rd_data.used) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_head;
                    wr_data  = '{used: 1'b0, run: r_rd_data.run, slack: r_rd_data.slack};
                    n_status = ST_OK;
                end else begin
                    n_status = ST_BAD_ADDR;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state resets; working registers are loaded before use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dv    <= n_dv;
        end
        r_b        <= n_b;
        r_skip     <= n_skip;
        r_mod      <= n_mod;
        r_count    <= n_count;
        r_n        <= n_n;
        r_slack    <= n_slack;
        r_head     <= n_head;
        r_status   <= n_status;
        r_alloc_ok <= n_alloc_ok;
    end

    // Result
    assign head_bytes        = ADDR_W'(r_head) << OFS_W;
    assign o_idle            = (r_state == S_IDLE);
    assign o_done            = (r_state == S_DONE);
    assign o_rsp.status      = r_status;
    assign o_rsp.run_address = r_alloc_ok ? (i_cfg.region_start + head_bytes) : '0;

endmodule

// ----- hw/rtl/aligned_block_allocator.sv -----
// Top level of the aligned block allocator: configuration registers,
// request channel and result register. Depends on aba_pkg and aba_engine.
//
// Usage:
//   Requests arrive on the in channel (i_in_valid / o_in_stall) with i_cmd,
//   i_length and i_address; one result per request leaves on the out channel
//   (o_out_valid / i_out_stall) with o_status and o_run_address. A transfer
//   happens at a clock edge with valid high and stall low.
//   Allocate scans the block table from block 0, one block per cycle, through
//   a single memory read port with registered read data; it visits up to
//   1024 blocks. A bad length is answered without a scan. Free reads and
//   rewrites one table word.
//   One request is in work at a time; the next is taken once the engine is
//   back to idle, even while the previous result still waits in the output
//   register.
//   Reset (synchronous, active low) starts a sweep that marks all 1024
//   blocks free; o_in_stall stays high during it, configuration writes are
//   taken as usual. When the receiver stalls, the result holds in the output
//   register and a second finished result waits in the engine.
//   Registers: region_start at byte address 0, max_length at 4.
module aligned_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aba_pkg::PADDR_W-1:0]         paddr,
    input  logic [aba_pkg::PDATA_W-1:0]         pwdata,
    output logic [aba_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic [aba_pkg::LEN_W-1:0]           i_length,
    input  logic [aba_pkg::ADDR_W-1:0]          i_address,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aba_pkg::STATUS_W-1:0]        o_status,
    output logic [aba_pkg::ADDR_W-1:0]          o_run_address
);
    import aba_pkg::*;

    logic [ADDR_W-1:0]   r_region_start;
    logic [MAXLEN_W-1:0] r_max_length;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]   r_run_address;

    logic cfg_wr;
    logic reg_sel;
    t_cfg cfg;
    t_req req;
    t_rsp rsp;
    logic eng_idle;
    logic eng_done;
    logic eng_take;
    logic in_xfer;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_max_length   <= MAXLEN_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == REG_REGION_START) begin
                r_region_start <= pwdata[ADDR_W-1:0];
            end else begin
                r_max_length <= pwdata[MAXLEN_W-1:0];
            end
        end
    end

    always_comb begin
        case (reg_sel)
            REG_REGION_START: prdata = PDATA_W'(r_region_start);
            REG_MAX_LENGTH:   prdata = PDATA_W'(r_max_length);
            default:          prdata = '0;
        endcase
    end

    assign cfg.region_start = r_region_start;
    assign cfg.max_length   = r_max_length;

    // Request side
    assign o_in_stall  = !eng_idle;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign req.cmd     = i_cmd;
    assign req.length  = i_length;
    assign req.address = i_address;

    aba_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (in_xfer),
        .i_req   (req),
        .o_idle  (eng_idle),
        .o_done  (eng_done),
        .o_rsp   (rsp),
        .i_take  (eng_take)
    );

    // Result register: loads when empty or when its content transfers out
    assign eng_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && eng_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (eng_done && eng_take) begin
            r_status      <= rsp.status;
            r_run_address <= rsp.run_address;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_run_address = r_run_address;

endmodule

// ----- hw/rtl/aba_checker.sv -----
// Port-level checks of the aligned block allocator, bound to the top level.
// Depends on aba_pkg and aligned_block_allocator_defines.svh.
`include "aligned_block_allocator_defines.svh"

module aba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [aba_pkg::STATUS_W-1:0] o_status,
    input logic [aba_pkg::ADDR_W-1:0]   o_run_address
);
    import aba_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pending;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Requests taken and not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    `ABA_ASSERT_NOW(a_err_no_addr, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_run_address == '0, "failed result carries an address")
    `ABA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_run_address), "stalled result changed")
    `ABA_ASSERT_NEXT_ANY(a_reset_quiet, i_clk, !i_rst_n, o_in_stall && !o_out_valid, "block not quiet after reset")
    `ABA_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n, o_out_valid, r_pending != 2'd0, "result without a request")
    `ABA_ASSERT_NOW(a_one_in_work, i_clk, i_rst_n, in_xfer, r_pending <= 2'd1, "request taken while engine busy")

endmodule

bind aligned_block_allocator aba_checker u_aba_checker (.*);
